/* src/binary_line_run_detector_assert.svh */
// Assertion macros shared by the run detector modules.
`ifndef BINARY_LINE_RUN_DETECTOR_ASSERT_SVH
`define BINARY_LINE_RUN_DETECTOR_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define BLRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BLRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/blrd_pkg.sv */
// Shared types and constants of the binary line run detector.
package blrd_pkg;

	localparam int COL_W = 11;
	localparam int NUM_W = 4;
	localparam int THR_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_LENGTH  = 2'd1;

	localparam logic [THR_W-1:0] WHITE_THRESHOLD_RST = 8'd150;
	localparam logic [COL_W-1:0] MIN_RUN_LENGTH_RST  = 11'd10;

	localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	// Classified pixel passed from front to back
	typedef struct packed {
		logic white;
	} pix_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic             pixel_white;
		logic             run_found;
		logic [COL_W-1:0] run_start;
		logic [COL_W-1:0] run_end;
		logic [COL_W-1:0] run_center;
		logic [NUM_W-1:0] run_number;
	} result_t;

endpackage

/* src/binary_line_run_detector.sv */
// Top level of the binary line run detector: config registers, front, queue and back.
// Path: an accepted pixel passes the front register, the queue and the result register in turn.
// Throughput: one pixel per clock; the front register, four-entry queue and result
// register each move one request per cycle and stall independently.
// Reset: asynchronous, active low; queues empty, row state zero,
// white_threshold = 150, min_run_length = 10.
module binary_line_run_detector #(
	parameter int LINE_WIDTH = 320
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	output logic                             empty,
	input  logic                             pop,
	output logic                             pixel_white,
	output logic                             run_found,
	output logic [10:0]                      run_start,
	output logic [10:0]                      run_end,
	output logic [10:0]                      run_center,
	output logic [3:0]                       run_number,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [blrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [blrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [blrd_pkg::THR_W-1:0] white_threshold_q;
	logic [blrd_pkg::COL_W-1:0] min_run_length_q;
	blrd_pkg::qstat_t           qstat;
	blrd_pkg::pix_t             fq_data, qb_data;
	blrd_pkg::result_t          result;
	logic                       q_push, q_pop, out_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_threshold_q <= blrd_pkg::WHITE_THRESHOLD_RST;
			min_run_length_q  <= blrd_pkg::MIN_RUN_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				blrd_pkg::REG_WHITE_THRESHOLD: white_threshold_q <= cfg_data[blrd_pkg::THR_W-1:0];
				blrd_pkg::REG_MIN_RUN_LENGTH:  min_run_length_q  <= cfg_data[blrd_pkg::COL_W-1:0];
				default: ;
			endcase
		end
	end

	blrd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.white_threshold (white_threshold_q),
		.qstat           (qstat),
		.q_push          (q_push),
		.q_data          (fq_data)
	);

	blrd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_i (q_push),
		.data_i (fq_data),
		.pop_i  (q_pop),
		.data_o (qb_data),
		.stat_o (qstat)
	);

	blrd_back #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.q_data         (qb_data),
		.q_pop          (q_pop),
		.min_run_length (min_run_length_q),
		.out_pop        (pop),
		.out_valid      (out_valid),
		.result         (result)
	);

	assign empty       = !out_valid;
	assign pixel_white = result.pixel_white;
	assign run_found   = result.run_found;
	assign run_start   = result.run_start;
	assign run_end     = result.run_end;
	assign run_center  = result.run_center;
	assign run_number  = result.run_number;

endmodule

/* src/blrd_front.sv */
// Front end: accepts a pixel, thresholds its averaged intensity, feeds the queue.
module blrd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic [blrd_pkg::THR_W-1:0]  white_threshold,
	input  blrd_pkg::qstat_t            qstat,
	output logic                        q_push,
	output blrd_pkg::pix_t              q_data
);

	// x/3 for 8-bit x: (x * 171) >> 9 is exact over 0..255
	function automatic logic [6:0] div3(input logic [7:0] x);
		logic [15:0] prod;
		prod = 16'(x) * 16'd171;
		return prod[15:9];
	endfunction

	logic [8:0]     level;
	logic           valid_s1;
	blrd_pkg::pix_t pix_s1;
	logic           adv;

	assign level = 9'(div3(red)) + 9'(div3(green)) + 9'(div3(blue));
	assign adv   = !valid_s1 || !qstat.full;
	assign full  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			pix_s1.white <= (level >= 9'(white_threshold));
		end
	end

	assign q_push = valid_s1 && !qstat.full;
	assign q_data = pix_s1;

endmodule

/* src/blrd_queue.sv */
// Short FIFO of classified pixels between front and back.
`include "binary_line_run_detector_assert.svh"

module blrd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_i,
	input  blrd_pkg::pix_t   data_i,
	input  logic             pop_i,
	output blrd_pkg::pix_t   data_o,
	output blrd_pkg::qstat_t stat_o
);

	blrd_pkg::pix_t                 mem [blrd_pkg::QUEUE_DEPTH];
	logic [blrd_pkg::QPTR_W-1:0]    wptr_q;
	logic [blrd_pkg::QPTR_W-1:0]    rptr_q;
	logic [blrd_pkg::QCNT_W-1:0]    count_q;

	localparam logic [blrd_pkg::QCNT_W-1:0] DEPTH_CNT =
		blrd_pkg::QCNT_W'(blrd_pkg::QUEUE_DEPTH);
	localparam logic [blrd_pkg::QPTR_W-1:0] LAST_PTR =
		blrd_pkg::QPTR_W'(blrd_pkg::QUEUE_DEPTH - 1);

	assign stat_o.full  = (count_q == DEPTH_CNT);
	assign stat_o.empty = (count_q == '0);
	assign data_o       = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push_i) begin
			mem[wptr_q] <= data_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_i) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (pop_i) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			case ({push_i, pop_i})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BLRD_ASSERT(a_q_no_overflow, !(push_i && stat_o.full && !pop_i), "queue overflow")
	`BLRD_ASSERT(a_q_no_underflow, !(pop_i && stat_o.empty), "queue underflow")

endmodule

/* src/blrd_back.sv */
// Back end: per-row run tracking and the result register.
`include "binary_line_run_detector_assert.svh"

module blrd_back #(
	parameter int LINE_WIDTH = 320
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  blrd_pkg::qstat_t            qstat,
	input  blrd_pkg::pix_t              q_data,
	output logic                        q_pop,
	input  logic [blrd_pkg::COL_W-1:0]  min_run_length,
	input  logic                        out_pop,
	output logic                        out_valid,
	output blrd_pkg::result_t           result
);

	localparam logic [blrd_pkg::COL_W-1:0] LAST_COL = blrd_pkg::COL_W'(LINE_WIDTH - 1);

	logic [blrd_pkg::COL_W-1:0] col_q, wlen_q, rbegin_q;
	logic [blrd_pkg::COL_W-1:0] col_n, wlen_n, rbegin_n;
	logic [blrd_pkg::NUM_W-1:0] runs_q, runs_n;
	logic                       prev_q, prev_n;
	logic                       out_valid_q;
	blrd_pkg::result_t          res_q, res_n;
	logic [blrd_pkg::COL_W:0]   mid_sum;
	logic [blrd_pkg::COL_W-1:0] wlen_inc;
	logic                       take;

	assign take      = !out_valid_q || out_pop;
	assign q_pop     = take && !qstat.empty;
	assign out_valid = out_valid_q;
	assign result    = res_q;

	assign wlen_inc = (wlen_q == blrd_pkg::COL_MAX) ? wlen_q : wlen_q + 1'b1;
	assign mid_sum  = {1'b0, rbegin_q} + {1'b0, col_q};

	always_comb begin
		wlen_n   = wlen_q;
		rbegin_n = rbegin_q;
		runs_n   = runs_q;
		res_n    = '0;
		res_n.pixel_white = q_data.white;
		if (col_q != '0) begin
			if (prev_q) begin
				wlen_n = wlen_inc;
				if (wlen_inc > min_run_length && !q_data.white) begin
					res_n.run_found  = 1'b1;
					res_n.run_start  = rbegin_q;
					res_n.run_end    = col_q;
					res_n.run_center = mid_sum[blrd_pkg::COL_W:1];
					res_n.run_number = runs_q;
					if (runs_q != blrd_pkg::NUM_MAX) begin
						runs_n = runs_q + 1'b1;
					end
				end
			end else begin
				wlen_n   = '0;
				rbegin_n = col_q;
			end
		end
		prev_n = q_data.white;
		col_n  = col_q + 1'b1;
		// last column of the row: start the next row clean
		if (col_q >= LAST_COL) begin
			col_n    = '0;
			prev_n   = 1'b0;
			wlen_n   = '0;
			rbegin_n = '0;
			runs_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			prev_q      <= 1'b0;
			wlen_q      <= '0;
			rbegin_q    <= '0;
			runs_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				col_q    <= col_n;
				prev_q   <= prev_n;
				wlen_q   <= wlen_n;
				rbegin_q <= rbegin_n;
				runs_q   <= runs_n;
			end
			if (take) begin
				out_valid_q <= !qstat.empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_n;
		end
	end

	`BLRD_ASSERT(a_found_on_black, !(out_valid_q && res_q.run_found && res_q.pixel_white), "run reported on a white pixel")
	`BLRD_ASSERT(a_start_before_end, !(out_valid_q && res_q.run_found && res_q.run_start >= res_q.run_end), "run start not before end")

endmodule
